// ===== hdl/mau_pkg.sv =====
package mau_pkg;

  localparam int COEF_WIDTH = 16;
  localparam int EXP_WIDTH  = 8;
  localparam int DATA_WIDTH = 32;

  // Exponent of a result carries one extra bit for sums and differences.
  localparam int EXPR_WIDTH = EXP_WIDTH + 1;
  // Magnitude of a coefficient: one bit more, so that the most negative value fits.
  localparam int MAG_WIDTH  = COEF_WIDTH + 1;
  localparam int NUM_EXT_WIDTH = (MAG_WIDTH > DATA_WIDTH) ? MAG_WIDTH : DATA_WIDTH;
  localparam int SHIFT_WIDTH   = $clog2(MAG_WIDTH);
  localparam int DIV_CNT_WIDTH = $clog2(MAG_WIDTH + 1);
  localparam int POW_CNT_WIDTH = EXP_WIDTH - 1;

  typedef enum logic [1:0] {
    OP_PRODUCT  = 2'd0,
    OP_QUOTIENT = 2'd1,
    OP_DERIV    = 2'd2,
    OP_EVAL     = 2'd3
  } op_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic pow_step;
    logic pow_finish;
    logic gcd_step;
    logic gcd_finish;
    logic div_step;
    logic div_a_finish;
    logic div_b_finish;
    logic publish;
  } mau_cmd_t;

  typedef struct packed {
    op_t  op;
    logic cb_zero;
    logic xv_zero;
    logic pow_done;
    logic gcd_done;
    logic div_done;
  } mau_stat_t;

endpackage

// ===== hdl/mau_if.sv =====
interface mau_in_if import mau_pkg::*; ();
  logic                         valid;
  logic                         ready;
  op_t                          op;
  logic signed [COEF_WIDTH-1:0] coef_a;
  logic signed [EXP_WIDTH-1:0]  exp_a;
  logic signed [COEF_WIDTH-1:0] coef_b;
  logic signed [EXP_WIDTH-1:0]  exp_b;
  logic signed [DATA_WIDTH-1:0] x_value;

  modport source (output valid, op, coef_a, exp_a, coef_b, exp_b, x_value, input ready);
  modport sink   (input valid, op, coef_a, exp_a, coef_b, exp_b, x_value, output ready);
endinterface

interface mau_out_if import mau_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] numerator;
  logic signed [COEF_WIDTH-1:0] denominator;
  logic signed [EXPR_WIDTH-1:0] exponent;
  logic                         status;

  modport source (output valid, numerator, denominator, exponent, status, input ready);
  modport sink   (input valid, numerator, denominator, exponent, status, output ready);
endinterface

// ===== hdl/mau_ctrl.sv =====
module mau_ctrl import mau_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  mau_stat_t stat,
  output mau_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_POW,
    S_GCD,
    S_DIV_A,
    S_DIV_B,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        case (stat.op)
          OP_QUOTIENT: state_nxt = stat.cb_zero ? S_DONE : S_GCD;
          OP_EVAL:     state_nxt = stat.xv_zero ? S_DONE : S_POW;
          default:     state_nxt = S_DONE;
        endcase
      end
      S_POW: begin
        if (stat.pow_done) begin
          cmd.pow_finish = 1'b1;
          state_nxt      = S_DONE;
        end else begin
          cmd.pow_step = 1'b1;
        end
      end
      S_GCD: begin
        if (stat.gcd_done) begin
          cmd.gcd_finish = 1'b1;
          state_nxt      = S_DIV_A;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIV_A: begin
        if (stat.div_done) begin
          cmd.div_a_finish = 1'b1;
          state_nxt        = S_DIV_B;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_DIV_B: begin
        if (stat.div_done) begin
          cmd.div_b_finish = 1'b1;
          state_nxt        = S_DONE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_DONE: begin
        // The result moves to the output register once the previous one has gone.
        if (!out_valid_r || out_ready) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/mau_dp.sv =====
module mau_dp import mau_pkg::*; (
  input  logic                         clk,
  input  mau_cmd_t                     cmd,
  output mau_stat_t                    stat,
  input  op_t                          op,
  input  logic signed [COEF_WIDTH-1:0] coef_a,
  input  logic signed [EXP_WIDTH-1:0]  exp_a,
  input  logic signed [COEF_WIDTH-1:0] coef_b,
  input  logic signed [EXP_WIDTH-1:0]  exp_b,
  input  logic signed [DATA_WIDTH-1:0] x_value,
  output logic signed [DATA_WIDTH-1:0] numerator,
  output logic signed [COEF_WIDTH-1:0] denominator,
  output logic signed [EXPR_WIDTH-1:0] exponent,
  output logic                         status
);

  // Operand registers
  op_t                          op_r;
  logic signed [COEF_WIDTH-1:0] ca_r, cb_r;
  logic signed [EXP_WIDTH-1:0]  ea_r, eb_r;
  logic signed [DATA_WIDTH-1:0] xv_r;

  // Working registers
  logic [DATA_WIDTH-1:0]    acc_r;
  logic [POW_CNT_WIDTH-1:0] pow_cnt_r;
  logic [MAG_WIDTH-1:0]     u_r, v_r, g_r;
  logic [SHIFT_WIDTH-1:0]   k_r;
  logic [MAG_WIDTH-1:0]     rem_r, dq_r;
  logic [DIV_CNT_WIDTH-1:0] div_cnt_r;

  // Pending result and output register
  logic signed [DATA_WIDTH-1:0] res_num_r, out_num_r;
  logic signed [COEF_WIDTH-1:0] res_den_r, out_den_r;
  logic signed [EXPR_WIDTH-1:0] res_exp_r, out_exp_r;
  logic                         res_st_r, out_st_r;

  logic signed [DATA_WIDTH-1:0] ca_ext32, cb_ext32, ea_ext32;
  logic [MAG_WIDTH-1:0]         ca_ext, cb_ext, ca_mag, cb_mag;
  logic                         ca_zero, cb_zero;
  logic [DATA_WIDTH-1:0]        mul_a, mul_b;
  logic [2*DATA_WIDTH-1:0]      mul_full;
  logic [DATA_WIDTH-1:0]        mul_lo;
  logic [MAG_WIDTH:0]           trial;
  logic                         trial_ge;
  logic [NUM_EXT_WIDTH-1:0]     quo_ext, quo_signed;
  logic [MAG_WIDTH-1:0]         quo_neg;
  logic signed [EXPR_WIDTH-1:0] prep_exp;
  logic                         prep_st;
  logic [MAG_WIDTH-1:0]         diff_uv, diff_vu;

  assign ca_ext32 = DATA_WIDTH'(ca_r);
  assign cb_ext32 = DATA_WIDTH'(cb_r);
  assign ea_ext32 = DATA_WIDTH'(ea_r);
  assign ca_ext   = MAG_WIDTH'(ca_r);
  assign cb_ext   = MAG_WIDTH'(cb_r);
  assign ca_mag   = ca_r[COEF_WIDTH-1] ? (MAG_WIDTH'(0) - ca_ext) : ca_ext;
  assign cb_mag   = cb_r[COEF_WIDTH-1] ? (MAG_WIDTH'(0) - cb_ext) : cb_ext;
  assign ca_zero  = (ca_r == '0);
  assign cb_zero  = (cb_r == '0);

  // One shared multiplier; only the low word of the product is kept.
  always_comb begin
    mul_a = acc_r;
    mul_b = xv_r;
    if (cmd.prep) begin
      mul_a = ca_ext32;
      mul_b = (op_r == OP_PRODUCT) ? cb_ext32 : ea_ext32;
    end else if (cmd.pow_finish) begin
      mul_b = ca_ext32;
    end
  end

  assign mul_full = (2*DATA_WIDTH)'(mul_a) * (2*DATA_WIDTH)'(mul_b);
  assign mul_lo   = mul_full[DATA_WIDTH-1:0];

  always_comb begin
    case (op_r)
      OP_PRODUCT:  prep_exp = EXPR_WIDTH'(ea_r) + EXPR_WIDTH'(eb_r);
      OP_QUOTIENT: prep_exp = EXPR_WIDTH'(ea_r) - EXPR_WIDTH'(eb_r);
      OP_DERIV:    prep_exp = EXPR_WIDTH'(ea_r) - EXPR_WIDTH'(1);
      default:     prep_exp = '0;
    endcase
  end

  assign prep_st = ca_zero || ((op_r == OP_PRODUCT || op_r == OP_QUOTIENT) && cb_zero);

  // Restoring division, one quotient bit per cycle.
  assign trial    = {rem_r, dq_r[MAG_WIDTH-1]};
  assign trial_ge = (trial >= {1'b0, g_r});

  // The divider's quotient, signed as the matching coefficient.
  assign quo_neg    = MAG_WIDTH'(0) - dq_r;
  assign quo_ext    = NUM_EXT_WIDTH'(dq_r);
  assign quo_signed = NUM_EXT_WIDTH'(0) - quo_ext;

  assign diff_uv = u_r - v_r;
  assign diff_vu = v_r - u_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= op;
      ca_r <= coef_a;
      ea_r <= exp_a;
      cb_r <= coef_b;
      eb_r <= exp_b;
      xv_r <= x_value;
    end

    if (cmd.prep) begin
      res_exp_r <= prep_exp;
      res_st_r  <= prep_st;
      res_den_r <= (op_r == OP_QUOTIENT && cb_zero) ? '0 : COEF_WIDTH'(1);
      res_num_r <= (op_r == OP_PRODUCT || op_r == OP_DERIV) ? mul_lo : '0;
      acc_r     <= DATA_WIDTH'(1);
      pow_cnt_r <= ea_r[EXP_WIDTH-1] ? '0 : ea_r[EXP_WIDTH-2:0];
      u_r       <= ca_mag;
      v_r       <= cb_mag;
      k_r       <= '0;
    end

    if (cmd.pow_step) begin
      acc_r     <= mul_lo;
      pow_cnt_r <= pow_cnt_r - 1'b1;
    end

    if (cmd.pow_finish) begin
      res_num_r <= mul_lo;
    end

    // Binary GCD: strip common factors of two, then subtract odd from odd.
    if (cmd.gcd_step) begin
      if (!u_r[0] && !v_r[0]) begin
        u_r <= u_r >> 1;
        v_r <= v_r >> 1;
        k_r <= k_r + 1'b1;
      end else if (!u_r[0]) begin
        u_r <= u_r >> 1;
      end else if (!v_r[0]) begin
        v_r <= v_r >> 1;
      end else if (u_r >= v_r) begin
        u_r <= diff_uv >> 1;
      end else begin
        v_r <= diff_vu >> 1;
      end
    end

    if (cmd.gcd_finish) begin
      g_r       <= (u_r | v_r) << k_r;
      rem_r     <= '0;
      dq_r      <= ca_mag;
      div_cnt_r <= DIV_CNT_WIDTH'(MAG_WIDTH);
    end

    if (cmd.div_step) begin
      rem_r     <= trial_ge ? MAG_WIDTH'(trial - {1'b0, g_r}) : trial[MAG_WIDTH-1:0];
      dq_r      <= {dq_r[MAG_WIDTH-2:0], trial_ge};
      div_cnt_r <= div_cnt_r - 1'b1;
    end

    if (cmd.div_a_finish) begin
      res_num_r <= ca_r[COEF_WIDTH-1] ? quo_signed[DATA_WIDTH-1:0] : quo_ext[DATA_WIDTH-1:0];
      rem_r     <= '0;
      dq_r      <= cb_mag;
      div_cnt_r <= DIV_CNT_WIDTH'(MAG_WIDTH);
    end

    if (cmd.div_b_finish) begin
      res_den_r <= cb_r[COEF_WIDTH-1] ? quo_neg[COEF_WIDTH-1:0] : dq_r[COEF_WIDTH-1:0];
    end

    if (cmd.publish) begin
      out_num_r <= res_num_r;
      out_den_r <= res_den_r;
      out_exp_r <= res_exp_r;
      out_st_r  <= res_st_r;
    end
  end

  assign stat.op       = op_r;
  assign stat.cb_zero  = cb_zero;
  assign stat.xv_zero  = (xv_r == '0);
  assign stat.pow_done = (pow_cnt_r == '0);
  assign stat.gcd_done = (u_r == '0) || (v_r == '0);
  assign stat.div_done = (div_cnt_r == '0);

  assign numerator   = out_num_r;
  assign denominator = out_den_r;
  assign exponent    = out_exp_r;
  assign status      = out_st_r;

endmodule

// ===== hdl/monomial_arith_unit.sv =====
// Product, derivative, quotient by zero and evaluate at zero pass from S_PREP straight to
// S_DONE; evaluate makes one pass through the shared 32x32 multiplier per power of x and one
// more for the coefficient; quotient runs the binary GCD loop and then the bit-serial divider,
// once for each coefficient.
// Throughput: one transaction at a time; the next is accepted while a result waits.
// Reset: synchronous, active low; clears the controller and the output valid flag.
module monomial_arith_unit import mau_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  mau_in_if.sink    in_ch,
  mau_out_if.source out_ch
);

  mau_cmd_t  cmd;
  mau_stat_t stat;

  mau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mau_dp u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .stat        (stat),
    .op          (in_ch.op),
    .coef_a      (in_ch.coef_a),
    .exp_a       (in_ch.exp_a),
    .coef_b      (in_ch.coef_b),
    .exp_b       (in_ch.exp_b),
    .x_value     (in_ch.x_value),
    .numerator   (out_ch.numerator),
    .denominator (out_ch.denominator),
    .exponent    (out_ch.exponent),
    .status      (out_ch.status)
  );

endmodule

// ===== tb/sv/monomial_checker.sv =====
module monomial_checker import mau_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  mau_in_if    in_ch,
  mau_out_if   out_ch,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [DATA_WIDTH-1:0] numerator;
    logic signed [COEF_WIDTH-1:0] denominator;
    logic signed [EXPR_WIDTH-1:0] exponent;
    logic                         status;
  } mono_result_t;

  mono_result_t expected_q[$];

  function automatic mono_result_t predict_monomial(
    op_t                          op,
    logic signed [COEF_WIDTH-1:0] ca,
    logic signed [EXP_WIDTH-1:0]  ea,
    logic signed [COEF_WIDTH-1:0] cb,
    logic signed [EXP_WIDTH-1:0]  eb,
    logic signed [DATA_WIDTH-1:0] xv
  );
    mono_result_t r;
    longint a, b, e1, e2, s;
    longint unsigned ma, mb, gx, gy, t;
    logic [DATA_WIDTH-1:0] pw, a32;
    int i;
    a  = ca;
    b  = cb;
    e1 = ea;
    e2 = eb;
    r.numerator   = '0;
    r.denominator = COEF_WIDTH'(1);
    r.exponent    = '0;
    r.status      = 1'b0;
    case (op)
      OP_PRODUCT: begin
        s = a * b;
        r.numerator = s[DATA_WIDTH-1:0];
        s = e1 + e2;
        r.exponent = s[EXPR_WIDTH-1:0];
        r.status = (a == 0) || (b == 0);
      end
      OP_QUOTIENT: begin
        s = e1 - e2;
        r.exponent = s[EXPR_WIDTH-1:0];
        r.status = (a == 0) || (b == 0);
        if (b == 0) begin
          r.denominator = '0;
        end else begin
          ma = (a < 0) ? -a : a;
          mb = (b < 0) ? -b : b;
          gx = ma;
          gy = mb;
          while (gy != 0) begin
            t  = gx % gy;
            gx = gy;
            gy = t;
          end
          // Both parts keep their own sign once divided by the positive GCD.
          s = (a < 0) ? -longint'(ma / gx) : longint'(ma / gx);
          r.numerator = s[DATA_WIDTH-1:0];
          s = (b < 0) ? -longint'(mb / gx) : longint'(mb / gx);
          r.denominator = s[COEF_WIDTH-1:0];
        end
      end
      OP_DERIV: begin
        s = a * e1;
        r.numerator = s[DATA_WIDTH-1:0];
        s = e1 - 1;
        r.exponent = s[EXPR_WIDTH-1:0];
        r.status = (a == 0);
      end
      default: begin
        r.status = (a == 0);
        if (xv != 0) begin
          pw = DATA_WIDTH'(1);
          for (i = 1; i <= e1; i++)
            pw = pw * xv;
          s = a;
          a32 = s[DATA_WIDTH-1:0];
          pw = pw * a32;
          r.numerator = pw;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    mono_result_t got, want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        expected_q.push_back(predict_monomial(in_ch.op, in_ch.coef_a, in_ch.exp_a,
                                              in_ch.coef_b, in_ch.exp_b, in_ch.x_value));
      if (out_ch.valid && out_ch.ready) begin
        got.numerator   = out_ch.numerator;
        got.denominator = out_ch.denominator;
        got.exponent    = out_ch.exponent;
        got.status      = out_ch.status;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result transaction with nothing outstanding: %s %0d %0d %0d %0b",
                     $realtime, "num/den/exp/st", got.numerator, got.denominator,
                     got.exponent, got.status);
        end else begin
          want = expected_q.pop_front();
          if (got.numerator !== want.numerator || got.denominator !== want.denominator ||
              got.exponent !== want.exponent || got.status !== want.status) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch: num %0d/%0d den %0d/%0d exp %0d/%0d st %0b/%0b (exp/act)",
                       $realtime, want.numerator, got.numerator, want.denominator,
                       got.denominator, want.exponent, got.exponent, want.status, got.status);
          end
        end
      end
      pending = expected_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_monomial_arith_unit.sv =====
module tb_monomial_arith_unit import mau_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1000;

  typedef struct {
    op_t                          op;
    logic signed [COEF_WIDTH-1:0] coef_a;
    logic signed [EXP_WIDTH-1:0]  exp_a;
    logic signed [COEF_WIDTH-1:0] coef_b;
    logic signed [EXP_WIDTH-1:0]  exp_b;
    logic signed [DATA_WIDTH-1:0] x_value;
  } mono_item_t;

  logic clk;
  logic rst_n;
  logic calm;
  int   errors;
  int   pending;

  mau_in_if  in_ch ();
  mau_out_if out_ch ();

  monomial_arith_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  monomial_checker chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .errors  (errors),
    .pending (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic mono_item_t item_of(op_t op, int ca, int ea, int cb, int eb, int xv);
    mono_item_t it;
    it.op      = op;
    it.coef_a  = ca[COEF_WIDTH-1:0];
    it.exp_a   = ea[EXP_WIDTH-1:0];
    it.coef_b  = cb[COEF_WIDTH-1:0];
    it.exp_b   = eb[EXP_WIDTH-1:0];
    it.x_value = xv;
    return it;
  endfunction

  function automatic int rand_coef();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) begin
      case ($urandom_range(0, 3))
        0: return -(1 << (COEF_WIDTH - 1));
        1: return (1 << (COEF_WIDTH - 1)) - 1;
        2: return -1;
        default: return 1;
      endcase
    end
    if (r < 5) return int'($urandom_range(0, 200)) - 100;
    return $urandom;
  endfunction

  function automatic int rand_exp();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0: return -(1 << (EXP_WIDTH - 1));
        1: return (1 << (EXP_WIDTH - 1)) - 1;
        2: return -1;
        default: return 0;
      endcase
    end
    if (r < 5) return int'($urandom_range(0, 14)) - 4;
    return $urandom;
  endfunction

  function automatic int rand_x();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) begin
      case ($urandom_range(0, 3))
        0: return int'(32'h8000_0000);
        1: return int'(32'h7fff_ffff);
        2: return -1;
        default: return 1;
      endcase
    end
    if (r < 4) return int'($urandom_range(0, 40)) - 20;
    return $urandom;
  endfunction

  task automatic push_item(input mono_item_t it);
    int gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= it.op;
    in_ch.coef_a  <= it.coef_a;
    in_ch.exp_a   <= it.exp_a;
    in_ch.coef_b  <= it.coef_b;
    in_ch.exp_b   <= it.exp_b;
    in_ch.x_value <= it.x_value;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  // Result side: ready held for random stretches, always high in calm phases.
  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm) begin
        out_ch.ready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 2) != 0);
        hold = idle_len();
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle = 0;
      else
        idle++;
    end
    $display("tb_monomial_arith_unit: errors");
    $finish;
  end

  initial begin
    mono_item_t directed_q[$];
    mono_item_t it;
    calm          = 1'b0;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.op      = OP_PRODUCT;
    in_ch.coef_a  = '0;
    in_ch.exp_a   = '0;
    in_ch.coef_b  = '0;
    in_ch.exp_b   = '0;
    in_ch.x_value = '0;

    // Extremes, sign handling of the quotient and the zero cases of each operation.
    directed_q.push_back(item_of(OP_PRODUCT, 32767, 127, 32767, 127, 5));
    directed_q.push_back(item_of(OP_PRODUCT, -32768, -128, -32768, -128, -5));
    directed_q.push_back(item_of(OP_PRODUCT, 0, 5, -7, 3, 0));
    directed_q.push_back(item_of(OP_PRODUCT, -32768, 127, 32767, -128, -1));
    directed_q.push_back(item_of(OP_QUOTIENT, 3, 4, -6, 1, 0));
    directed_q.push_back(item_of(OP_QUOTIENT, -12, 0, 18, 0, 7));
    directed_q.push_back(item_of(OP_QUOTIENT, 0, -128, -5, 127, 0));
    directed_q.push_back(item_of(OP_QUOTIENT, 9, 127, 0, -128, 0));
    directed_q.push_back(item_of(OP_QUOTIENT, -32768, 1, -32768, 1, 0));
    directed_q.push_back(item_of(OP_QUOTIENT, 1, 0, -32768, 0, 0));
    directed_q.push_back(item_of(OP_QUOTIENT, -32768, 0, 1, 0, 0));
    directed_q.push_back(item_of(OP_QUOTIENT, 0, 0, 0, 0, 0));
    directed_q.push_back(item_of(OP_DERIV, 32767, 127, -1, -1, -1));
    directed_q.push_back(item_of(OP_DERIV, -32768, -128, 0, 0, 0));
    directed_q.push_back(item_of(OP_DERIV, 0, 0, 4, 4, 4));
    directed_q.push_back(item_of(OP_DERIV, 5, 0, 0, 0, 0));
    directed_q.push_back(item_of(OP_EVAL, 7, 5, 1, 1, 0));
    directed_q.push_back(item_of(OP_EVAL, 3, 0, 0, 0, 123));
    directed_q.push_back(item_of(OP_EVAL, -4, -128, 0, 0, -1));
    directed_q.push_back(item_of(OP_EVAL, 1, 127, 0, 0, -1));
    directed_q.push_back(item_of(OP_EVAL, -32768, 127, -1, -1, int'(32'h8000_0000)));
    directed_q.push_back(item_of(OP_EVAL, 2, 31, 0, 0, 2));
    directed_q.push_back(item_of(OP_EVAL, 0, 10, 0, 0, 3));
    directed_q.push_back(item_of(OP_EVAL, 32767, 3, 0, 0, int'(32'h7fff_ffff)));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_q[i])
      push_item(directed_q[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Every fourth block of a hundred transactions runs with no idling at all.
      calm = ((n / 100) % 4 == 3);
      it = item_of(op_t'($urandom_range(0, 3)), rand_coef(), rand_exp(), rand_coef(),
                   rand_exp(), rand_x());
      push_item(it);
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    wait (pending == 0);
    repeat (30) @(posedge clk);
    if (errors == 0)
      $display("tb_monomial_arith_unit: clean");
    else
      $display("tb_monomial_arith_unit: errors");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/mau_pkg.sv
hdl/mau_if.sv
hdl/mau_ctrl.sv
hdl/mau_dp.sv
hdl/monomial_arith_unit.sv
tb/sv/monomial_checker.sv
tb/sv/tb_monomial_arith_unit.sv
